// ----- rtl/perlin_noise_2d_defines.svh -----
// assertion macros for the perlin noise block
`ifndef PERLIN_NOISE_2D_DEFINES_SVH
`define PERLIN_NOISE_2D_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define PN2D_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define PN2D_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PN2D_ASSERT_NOW(label, ante, cons, msg)
`define PN2D_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/pn2d_pkg.sv -----
// shared types, widths and constants of the perlin noise block
`default_nettype none

package pn2d_pkg;

   // permutation table
   localparam int TABLE_SIZE = 256;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int ENTRY_W    = 8;

   // internal fixed-point widths
   localparam int Q_W     = 16;
   localparam int WIDE_W  = Q_W + Q_W;
   localparam int OFS_W   = Q_W + 2;
   localparam int GRAD_W  = Q_W + 3;
   localparam int DIFF_W  = GRAD_W + 1;
   localparam int FADE_W  = Q_W + 1;
   localparam int PROD_W  = FADE_W + 1 + DIFF_W;
   localparam int DIV_W   = PROD_W - Q_W;
   localparam int NOISE_W = 16;

   // fade polynomial 6t^5 - 15t^4 + 10t^3
   localparam int FADE_C6  = 6;
   localparam int FADE_C15 = 15;
   localparam int FADE_C10 = 10;
   localparam int SQ_W     = Q_W + Q_W;
   localparam int CUBE_W   = SQ_W + Q_W;
   localparam int P_W      = SQ_W + 4;
   localparam int P16_W    = P_W - Q_W;
   localparam int FP_W     = Q_W + P16_W;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   // pipeline stages
   localparam int ST_READ_A  = 0;
   localparam int ST_READ_B  = 1;
   localparam int ST_GRAD    = 2;
   localparam int ST_FADE    = 3;
   localparam int ST_MUL_X   = 4;
   localparam int ST_LERP_X  = 5;
   localparam int ST_DIFF_Y  = 6;
   localparam int ST_MUL_Y   = 7;
   localparam int ST_LERP_Y  = 8;
   localparam int ST_OUT     = 9;
   localparam int NUM_STAGES = 10;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

endpackage

`default_nettype wire

// ----- rtl/pn2d_perm_ram.sv -----
// permutation table copy: one write port, two registered read ports
`default_nettype none

module pn2d_perm_ram import pn2d_pkg::*; (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr_a,
   input  wire logic [IDX_W-1:0]   rd_addr_b,
   output logic      [ENTRY_W-1:0] rd_data_a,
   output logic      [ENTRY_W-1:0] rd_data_b
);

   logic [ENTRY_W-1:0] perm_mem [TABLE_SIZE];
   logic [ENTRY_W-1:0] rd_a_ff;
   logic [ENTRY_W-1:0] rd_b_ff;

   // read returns the contents before a write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= perm_mem[rd_addr_a];
         rd_b_ff <= perm_mem[rd_addr_b];
      end
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ----- rtl/pn2d_fade.sv -----
// three-stage quintic fade of one Q0.16 fraction
`default_nettype none

module pn2d_fade import pn2d_pkg::*; (
   input  wire logic              clock,
   input  wire stage_vec_type     stage_en,
   input  wire logic [Q_W-1:0]    frac,
   output logic      [FADE_W-1:0] fade
);

   logic [SQ_W-1:0]   sq_ff;
   logic [SQ_W-1:0]   sq_in;
   logic [Q_W-1:0]    f_ff;
   logic [CUBE_W-1:0] cube;
   logic [P_W-1:0]    poly;
   logic [Q_W-1:0]    t3_ff;
   logic [Q_W-1:0]    t3_in;
   logic [P16_W-1:0]  p16_ff;
   logic [P16_W-1:0]  p16_in;
   logic [FP_W-1:0]   fprod;
   logic [FADE_W-1:0] fade_ff;
   logic [FADE_W-1:0] fade_in;

   always_comb begin
      sq_in  = SQ_W'(frac) * SQ_W'(frac);
      cube   = CUBE_W'(sq_ff) * CUBE_W'(f_ff);
      t3_in  = cube[CUBE_W-1 -: Q_W];
      // never negative, so modular arithmetic is exact
      poly   = (P_W'(FADE_C10) << SQ_W) + P_W'(sq_ff) * P_W'(FADE_C6)
             - ((P_W'(f_ff) * P_W'(FADE_C15)) << Q_W);
      p16_in = poly[P_W-1:Q_W];
      fprod  = FP_W'(t3_ff) * FP_W'(p16_ff);
      fade_in = fprod[Q_W +: FADE_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_READ_B]) begin
         sq_ff <= sq_in;
         f_ff  <= frac;
      end
      if (stage_en[ST_GRAD]) begin
         t3_ff  <= t3_in;
         p16_ff <= p16_in;
      end
      if (stage_en[ST_FADE]) begin
         fade_ff <= fade_in;
      end
   end

   assign fade = fade_ff;

endmodule

`default_nettype wire

// ----- rtl/pn2d_blend.sv -----
// corner gradients and bilinear interpolation pipeline
`default_nettype none

module pn2d_blend import pn2d_pkg::*; (
   input  wire logic                      clock,
   input  wire stage_vec_type             stage_en,
   input  wire logic [Q_W-1:0]            frac_x,
   input  wire logic [Q_W-1:0]            frac_y,
   input  wire logic [IDX_W-1:0]          hash_aa,
   input  wire logic [IDX_W-1:0]          hash_ab,
   input  wire logic [IDX_W-1:0]          hash_ba,
   input  wire logic [IDX_W-1:0]          hash_bb,
   input  wire logic [FADE_W-1:0]         fade_u,
   input  wire logic [FADE_W-1:0]         fade_v,
   output logic signed [NOISE_W-1:0]      noise
);

   // four-direction gradient: the sum of +-dx and +-dy, picked by hash bits
   function automatic logic signed [GRAD_W-1:0] grad(
      input logic        [IDX_W-1:0] hash,
      input logic signed [OFS_W-1:0] dx,
      input logic signed [OFS_W-1:0] dy
   );
      logic signed [GRAD_W-1:0] a;
      logic signed [GRAD_W-1:0] b;
      a = hash[2] ? GRAD_W'(dy) : GRAD_W'(dx);
      b = hash[2] ? GRAD_W'(dx) : GRAD_W'(dy);
      if (hash[0]) a = -a;
      if (hash[1]) b = -b;
      return a + b;
   endfunction

   // product scaled down by 2^16, rounded toward zero
   function automatic logic signed [DIV_W-1:0] scale_down(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [DIV_W-1:0] q;
      q = p[PROD_W-1:Q_W];
      if (p[PROD_W-1] && (p[Q_W-1:0] != '0)) q = q + DIV_W'(1);
      return q;
   endfunction

   logic [Q_W-1:0] fx_ff;
   logic [Q_W-1:0] fy_ff;
   logic signed [OFS_W-1:0] dx0, dx1, dy0, dy1;

   logic signed [GRAD_W-1:0] g_aa_ff, g_ab_ff, g_ba_ff, g_bb_ff;
   logic signed [GRAD_W-1:0] g_aa_in, g_ab_in, g_ba_in, g_bb_in;

   logic signed [DIFF_W-1:0] d_lo_ff, d_hi_ff, d_lo_in, d_hi_in;
   logic signed [GRAD_W-1:0] ga3_ff, gb3_ff;

   logic signed [PROD_W-1:0] p_lo_ff, p_hi_ff, p_lo_in, p_hi_in;
   logic signed [GRAD_W-1:0] ga4_ff, gb4_ff;
   logic [FADE_W-1:0]        v4_ff, v5_ff, v6_ff;

   logic signed [GRAD_W-1:0] x1_ff, x2_ff, x1_in, x2_in;

   logic signed [DIFF_W-1:0] dd_ff, dd_in;
   logic signed [GRAD_W-1:0] x1_6_ff, x1_7_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [GRAD_W-1:0] r_ff, r_in;

   logic signed [GRAD_W-3:0]  q4;
   logic signed [NOISE_W-1:0] noise_ff, noise_in;

   always_comb begin
      dx0 = $signed({2'b00, fx_ff});
      dx1 = $signed({2'b11, fx_ff});
      dy0 = $signed({2'b00, fy_ff});
      dy1 = $signed({2'b11, fy_ff});

      g_aa_in = grad(hash_aa, dx0, dy0);
      g_ba_in = grad(hash_ba, dx1, dy0);
      g_ab_in = grad(hash_ab, dx0, dy1);
      g_bb_in = grad(hash_bb, dx1, dy1);

      d_lo_in = DIFF_W'(g_ba_ff) - DIFF_W'(g_aa_ff);
      d_hi_in = DIFF_W'(g_bb_ff) - DIFF_W'(g_ab_ff);

      p_lo_in = PROD_W'($signed({1'b0, fade_u})) * PROD_W'(d_lo_ff);
      p_hi_in = PROD_W'($signed({1'b0, fade_u})) * PROD_W'(d_hi_ff);

      x1_in = GRAD_W'(DIV_W'(ga4_ff) + scale_down(p_lo_ff));
      x2_in = GRAD_W'(DIV_W'(gb4_ff) + scale_down(p_hi_ff));

      dd_in   = DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
      prod_in = PROD_W'($signed({1'b0, v6_ff})) * PROD_W'(dd_ff);
      r_in    = GRAD_W'(DIV_W'(x1_7_ff) + scale_down(prod_ff));

      // divide by four toward zero, then clamp
      q4 = r_ff[GRAD_W-1:2];
      if (r_ff[GRAD_W-1] && (r_ff[1:0] != 2'b00)) q4 = q4 + (GRAD_W-2)'(1);
      if (q4[GRAD_W-3] != q4[NOISE_W-1]) begin
         noise_in = q4[GRAD_W-3] ? NOISE_MIN : NOISE_MAX;
      end else begin
         noise_in = q4[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_READ_B]) begin
         fx_ff <= frac_x;
         fy_ff <= frac_y;
      end
      if (stage_en[ST_GRAD]) begin
         g_aa_ff <= g_aa_in;
         g_ab_ff <= g_ab_in;
         g_ba_ff <= g_ba_in;
         g_bb_ff <= g_bb_in;
      end
      if (stage_en[ST_FADE]) begin
         d_lo_ff <= d_lo_in;
         d_hi_ff <= d_hi_in;
         ga3_ff  <= g_aa_ff;
         gb3_ff  <= g_ab_ff;
      end
      if (stage_en[ST_MUL_X]) begin
         p_lo_ff <= p_lo_in;
         p_hi_ff <= p_hi_in;
         ga4_ff  <= ga3_ff;
         gb4_ff  <= gb3_ff;
         v4_ff   <= fade_v;
      end
      if (stage_en[ST_LERP_X]) begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         v5_ff <= v4_ff;
      end
      if (stage_en[ST_DIFF_Y]) begin
         dd_ff   <= dd_in;
         x1_6_ff <= x1_ff;
         v6_ff   <= v5_ff;
      end
      if (stage_en[ST_MUL_Y]) begin
         prod_ff <= prod_in;
         x1_7_ff <= x1_6_ff;
      end
      if (stage_en[ST_LERP_Y]) begin
         r_ff <= r_in;
      end
      if (stage_en[ST_OUT]) begin
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule

`default_nettype wire

// ----- rtl/perlin_noise_2d.sv -----
// top level of the two-dimensional perlin noise generator
`default_nettype none

`include "perlin_noise_2d_defines.svh"

// Ten-stage pipeline that takes one request per cycle while req_ready is high,
// load or evaluate. An evaluate's response becomes valid once its point reaches
// the ST_OUT stage and is taken while rsp_ready is high. The six
// table lookups of each point come from three copies of the 256-byte
// permutation table, each with two read ports; a load request writes all three
// copies at once and gives no response. The first copy gives the two column
// hashes, the other two then give the four corner hashes in ST_READ_B. Each
// stage moves on whenever a later stage has room, so req_ready falls only
// while reset is high or when all ten stages hold a point and the response is
// not taken. The table comes out of reset unwritten: load every entry before
// the first evaluate.
module perlin_noise_2d import pn2d_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_op,
   input  wire logic [15:0]               req_x,
   input  wire logic [15:0]               req_y,
   input  wire logic [IDX_W-1:0]          req_table_index,
   input  wire logic [ENTRY_W-1:0]        req_table_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [NOISE_W-1:0]      rsp_noise
);

   localparam int SHIFT = Q_W - FRAC_BITS;

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type stage_en;

   logic              accept;
   logic              load_wr;
   logic [WIDE_W-1:0] x_wide;
   logic [WIDE_W-1:0] y_wide;
   logic [IDX_W-1:0]  xi;
   logic [IDX_W-1:0]  xi_next;

   logic [Q_W-1:0]    fx_ff;
   logic [Q_W-1:0]    fy_ff;
   logic [IDX_W-1:0]  yi_ff;

   logic [ENTRY_W-1:0] pa, pb;
   logic [ENTRY_W-1:0] hash_aa, hash_ab, hash_ba, hash_bb;
   logic [IDX_W-1:0]   addr_aa, addr_ab, addr_ba, addr_bb;
   logic [FADE_W-1:0]  fade_u, fade_v;

   // a stage may load when it or any later stage has room
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_en[i] = rsp_ready || (((~valid_ff) >> i) != '0);
      end
   end

   assign req_ready = stage_en[ST_READ_A] && !reset;
   assign accept    = req_valid && req_ready;
   assign load_wr   = accept && (req_op == OP_LOAD);
   assign rsp_valid = valid_ff[ST_OUT];

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[ST_READ_A]) begin
         valid_in[ST_READ_A] = req_valid && (req_op == OP_EVAL);
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // split coordinates into cell index and Q0.16 fraction
   always_comb begin
      x_wide  = WIDE_W'(req_x) << SHIFT;
      y_wide  = WIDE_W'(req_y) << SHIFT;
      xi      = x_wide[Q_W +: IDX_W];
      xi_next = xi + IDX_W'(1);
      addr_aa = IDX_W'(pa) + yi_ff;
      addr_ab = addr_aa + IDX_W'(1);
      addr_ba = IDX_W'(pb) + yi_ff;
      addr_bb = addr_ba + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_READ_A]) begin
         fx_ff <= x_wide[Q_W-1:0];
         fy_ff <= y_wide[Q_W-1:0];
         yi_ff <= y_wide[Q_W +: IDX_W];
      end
   end

   pn2d_perm_ram u_ram_col (
      .clock     (clock),
      .wr_en     (load_wr),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (stage_en[ST_READ_A]),
      .rd_addr_a (xi),
      .rd_addr_b (xi_next),
      .rd_data_a (pa),
      .rd_data_b (pb)
   );

   pn2d_perm_ram u_ram_lo (
      .clock     (clock),
      .wr_en     (load_wr),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (stage_en[ST_READ_B]),
      .rd_addr_a (addr_aa),
      .rd_addr_b (addr_ab),
      .rd_data_a (hash_aa),
      .rd_data_b (hash_ab)
   );

   pn2d_perm_ram u_ram_hi (
      .clock     (clock),
      .wr_en     (load_wr),
      .wr_addr   (req_table_index),
      .wr_data   (req_table_value),
      .rd_en     (stage_en[ST_READ_B]),
      .rd_addr_a (addr_ba),
      .rd_addr_b (addr_bb),
      .rd_data_a (hash_ba),
      .rd_data_b (hash_bb)
   );

   pn2d_fade u_fade_x (
      .clock    (clock),
      .stage_en (stage_en),
      .frac     (fx_ff),
      .fade     (fade_u)
   );

   pn2d_fade u_fade_y (
      .clock    (clock),
      .stage_en (stage_en),
      .frac     (fy_ff),
      .fade     (fade_v)
   );

   pn2d_blend u_blend (
      .clock    (clock),
      .stage_en (stage_en),
      .frac_x   (fx_ff),
      .frac_y   (fy_ff),
      .hash_aa  (hash_aa),
      .hash_ab  (hash_ab),
      .hash_ba  (hash_ba),
      .hash_bb  (hash_bb),
      .fade_u   (fade_u),
      .fade_v   (fade_v),
      .noise    (rsp_noise)
   );

   `PN2D_ASSERT_NOW(a_full_stall, ((&valid_ff) && !rsp_ready), !req_ready, "ready while full")
   `PN2D_ASSERT_NEXT(a_eval_enters, (accept && req_op == OP_EVAL), valid_ff[ST_READ_A], "eval lost")
   `PN2D_ASSERT_NEXT(a_load_silent, load_wr, !valid_ff[ST_READ_A], "load made a point")
   `PN2D_ASSERT_NOW(a_en_order, stage_en[ST_OUT], stage_en[ST_READ_A], "stage enable order")

endmodule

`default_nettype wire
